FILE: sv/cpd_pkg.sv
// Shared types and constants for the contour point decimator.
package cpd_pkg;

   localparam int COORD_BITS   = 12;
   localparam int THR_BITS     = 8;
   localparam int CAI_BITS     = 10;
   localparam int INDEX_BITS   = 11;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DAT_BITS = 10;

   localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_STEP_THRESHOLD    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_CLOSE_RADIUS      = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_CLOSE_AFTER_INDEX = 2'd2;

   localparam logic [THR_BITS-1:0] STEP_THRESHOLD_RESET    = 8'd10;
   localparam logic [THR_BITS-1:0] CLOSE_RADIUS_RESET      = 8'd10;
   localparam logic [CAI_BITS-1:0] CLOSE_AFTER_INDEX_RESET = 10'd10;

   localparam int QDEPTH    = 4;
   localparam int QPTR_BITS = 2;
   localparam int QCNT_BITS = 3;
   localparam logic [QCNT_BITS-1:0] QDEPTH_CNT = 3'd4;

   // one classified item waiting for the back end
   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] origin_x;
      logic [COORD_BITS-1:0] origin_y;
      logic                  emit_point;
      logic                  emit_close;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

FILE: sv/contour_point_decimator.sv
// Contour point decimator: top level joining front end, queue and back end.
//
// Contour points enter on the req_ channel (valid/stall); an item is taken at a
// clock edge with req_valid high and req_stall low. Kept points leave on the rsp_
// channel with the same handshake. The csr_ port writes step_threshold (0),
// close_radius (1) and close_after_index (2); write only while idle.
// A start item always yields its point. Later items yield nothing, their point,
// the closing origin copy (rsp_run_closed high), or the point and then the
// closing copy. After closure items are dropped until the next start.
// A taken item is written into the queue; the output register then loads it from
// the queue head, and rsp_valid rises with that load.
// Throughput: one item per cycle unless the queue is full. Classification is one
// subtract-and-compare stage; a two-result item uses the output register for both.
// A four-entry queue sits between classification and the output register, so
// input keeps flowing while the receiver stalls until the queue fills, and
// req_stall then follows the queue's full flag. Results are held while stalled.
// Reset (synchronous) restores the register defaults, empties the queue and
// leaves the block waiting for a start item.
module contour_point_decimator
   import cpd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [COORD_BITS-1:0]   req_point_x,
   input  logic [COORD_BITS-1:0]   req_point_y,
   input  logic                    req_run_start,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [COORD_BITS-1:0]   rsp_out_x,
   output logic [COORD_BITS-1:0]   rsp_out_y,
   output logic                    rsp_run_closed,
   input  logic                    csr_write_enable,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_DAT_BITS-1:0] csr_write_data
);

   qstat_type q_stat;
   entry_type push_entry, head;
   logic      push, pop;

   cpd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_run_start    (req_run_start),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .q_stat           (q_stat),
      .push             (push),
      .push_entry       (push_entry)
   );

   cpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   cpd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_stat         (q_stat),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_run_closed (rsp_run_closed)
   );

endmodule

FILE: sv/cpd_front.sv
// Front end: accepts points, keeps run state and classifies each item.
module cpd_front
   import cpd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [COORD_BITS-1:0]   req_point_x,
   input  logic [COORD_BITS-1:0]   req_point_y,
   input  logic                    req_run_start,
   input  logic                    csr_write_enable,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_DAT_BITS-1:0] csr_write_data,
   input  qstat_type               q_stat,
   output logic                    push,
   output entry_type               push_entry
);

   logic [THR_BITS-1:0]   step_threshold_ff, step_threshold_in;
   logic [THR_BITS-1:0]   close_radius_ff, close_radius_in;
   logic [CAI_BITS-1:0]   close_after_index_ff, close_after_index_in;
   logic [COORD_BITS-1:0] kept_x_ff, kept_x_in, kept_y_ff, kept_y_in;
   logic [COORD_BITS-1:0] origin_x_ff, origin_x_in, origin_y_ff, origin_y_in;
   logic [INDEX_BITS-1:0] input_index_ff, input_index_in, index_next;
   logic                  run_done_ff, run_done_in;
   logic                  accept, step_hit, close_hit;
   logic [COORD_BITS-1:0] dx_kept, dy_kept, dx_origin, dy_origin;

   function automatic logic [COORD_BITS-1:0] absdiff(input logic [COORD_BITS-1:0] a,
                                                     input logic [COORD_BITS-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   assign req_stall = q_stat.full;
   assign accept    = req_valid && !q_stat.full;

   assign dx_kept   = absdiff(req_point_x, kept_x_ff);
   assign dy_kept   = absdiff(req_point_y, kept_y_ff);
   assign dx_origin = absdiff(req_point_x, origin_x_ff);
   assign dy_origin = absdiff(req_point_y, origin_y_ff);

   assign index_next = (input_index_ff < INDEX_MAX) ? input_index_ff + 1'b1 : input_index_ff;

   assign step_hit = (dx_kept > COORD_BITS'(step_threshold_ff))
                  || (dy_kept > COORD_BITS'(step_threshold_ff));
   assign close_hit = (index_next > INDEX_BITS'(close_after_index_ff))
                   && (dx_origin < COORD_BITS'(close_radius_ff))
                   && (dy_origin < COORD_BITS'(close_radius_ff));

   always_comb begin
      step_threshold_in    = step_threshold_ff;
      close_radius_in      = close_radius_ff;
      close_after_index_in = close_after_index_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_STEP_THRESHOLD:    step_threshold_in    = csr_write_data[THR_BITS-1:0];
            REG_CLOSE_RADIUS:      close_radius_in      = csr_write_data[THR_BITS-1:0];
            REG_CLOSE_AFTER_INDEX: close_after_index_in = csr_write_data[CAI_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      kept_x_in      = kept_x_ff;
      kept_y_in      = kept_y_ff;
      origin_x_in    = origin_x_ff;
      origin_y_in    = origin_y_ff;
      input_index_in = input_index_ff;
      run_done_in    = run_done_ff;
      push           = 1'b0;
      push_entry.x          = req_point_x;
      push_entry.y          = req_point_y;
      push_entry.origin_x   = origin_x_ff;
      push_entry.origin_y   = origin_y_ff;
      push_entry.emit_point = step_hit;
      push_entry.emit_close = close_hit;
      if (accept) begin
         if (req_run_start) begin
            kept_x_in      = req_point_x;
            kept_y_in      = req_point_y;
            origin_x_in    = req_point_x;
            origin_y_in    = req_point_y;
            input_index_in = '0;
            run_done_in    = 1'b0;
            push           = 1'b1;
            push_entry.emit_point = 1'b1;
            push_entry.emit_close = 1'b0;
         end else if (!run_done_ff) begin
            input_index_in = index_next;
            if (step_hit) begin
               kept_x_in = req_point_x;
               kept_y_in = req_point_y;
            end
            if (close_hit) run_done_in = 1'b1;
            push = step_hit || close_hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_threshold_ff    <= STEP_THRESHOLD_RESET;
         close_radius_ff      <= CLOSE_RADIUS_RESET;
         close_after_index_ff <= CLOSE_AFTER_INDEX_RESET;
         kept_x_ff            <= '0;
         kept_y_ff            <= '0;
         origin_x_ff          <= '0;
         origin_y_ff          <= '0;
         input_index_ff       <= '0;
         run_done_ff          <= 1'b1;
      end else begin
         step_threshold_ff    <= step_threshold_in;
         close_radius_ff      <= close_radius_in;
         close_after_index_ff <= close_after_index_in;
         kept_x_ff            <= kept_x_in;
         kept_y_ff            <= kept_y_in;
         origin_x_ff          <= origin_x_in;
         origin_y_ff          <= origin_y_in;
         input_index_ff       <= input_index_in;
         run_done_ff          <= run_done_in;
      end
   end

   a_start_opens_run: assert property (@(posedge clock) disable iff (reset)
      accept && req_run_start |=> !run_done_ff && input_index_ff == '0)
      else $error("start item did not open a run");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full)
      else $error("push into full queue");

   a_idle_drops: assert property (@(posedge clock) disable iff (reset)
      accept && !req_run_start && run_done_ff |-> !push)
      else $error("item pushed while waiting for a start");

endmodule

FILE: sv/cpd_queue.sv
// Short FIFO of classified items between front and back end.
module cpd_queue
   import cpd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output qstat_type q_stat
);

   entry_type             entries_ff [QDEPTH];
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;

   assign head         = entries_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == QDEPTH_CNT);
   assign q_stat.empty = (count_ff == '0);

   always_comb begin
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QDEPTH_CNT)
      else $error("queue count overflow");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty queue");

   a_fill_tracks: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not follow push");

endmodule

FILE: sv/cpd_back.sv
// Back end: turns queued items into one or two results through an output register.
module cpd_back
   import cpd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  entry_type             head,
   input  qstat_type             q_stat,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COORD_BITS-1:0] rsp_out_x,
   output logic [COORD_BITS-1:0] rsp_out_y,
   output logic                  rsp_run_closed
);

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic                  closed_ff, closed_in;
   logic                  second_ff, second_in;   // point part of a two-result item is out
   logic                  load, head_valid;

   assign head_valid = !q_stat.empty;
   assign load       = head_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      closed_in    = closed_ff;
      second_in    = second_ff;
      pop          = 1'b0;
      if (!rsp_valid_ff || !rsp_stall) rsp_valid_in = head_valid;
      if (load) begin
         if (head.emit_point && !second_ff) begin
            out_x_in  = head.x;
            out_y_in  = head.y;
            closed_in = 1'b0;
            if (head.emit_close) second_in = 1'b1;
            else pop = 1'b1;
         end else begin
            out_x_in  = head.origin_x;
            out_y_in  = head.origin_y;
            closed_in = 1'b1;
            second_in = 1'b0;
            pop       = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         second_ff    <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      out_x_ff  <= out_x_in;
      out_y_ff  <= out_y_in;
      closed_ff <= closed_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_x      = out_x_ff;
   assign rsp_out_y      = out_y_ff;
   assign rsp_run_closed = closed_ff;

   a_second_has_head: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> head_valid && head.emit_point && head.emit_close)
      else $error("second result pending without a two-result item");

   a_pop_loads: assert property (@(posedge clock) disable iff (reset)
      pop |-> load)
      else $error("item popped without a result loaded");

   a_second_then_close: assert property (@(posedge clock) disable iff (reset)
      second_ff && load |=> rsp_valid_ff && closed_ff && !second_ff)
      else $error("closing result did not follow the point result");

endmodule

FILE: tb/contour_point_decimator_test.sv
// Self-checking testbench for the contour point decimator: predictor, driver and monitor.
module contour_point_decimator_test;
   import cpd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 80;
   localparam int IDLE_PCT     = 19;

   typedef struct {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic                  start;
   } contour_point_type;

   typedef struct {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic                  closed;
   } kept_point_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [COORD_BITS-1:0]   req_point_x = '0;
   logic [COORD_BITS-1:0]   req_point_y = '0;
   logic                    req_run_start = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [COORD_BITS-1:0]   rsp_out_x;
   logic [COORD_BITS-1:0]   rsp_out_y;
   logic                    rsp_run_closed;
   logic                    csr_write_enable = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_DAT_BITS-1:0] csr_write_data = '0;

   contour_point_decimator i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_run_start    (req_run_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_run_closed   (rsp_run_closed),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   contour_point_type pending_points[$];
   kept_point_type    expected_points[$];

   int error_count   = 0;
   int cycle_count   = 0;
   int send_idle_pct = IDLE_PCT;
   int recv_idle_pct = IDLE_PCT;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   // decimator state as predicted
   int                    step_limit  = STEP_THRESHOLD_RESET;
   int                    close_limit = CLOSE_RADIUS_RESET;
   int                    close_after = CLOSE_AFTER_INDEX_RESET;
   logic [COORD_BITS-1:0] last_kept_x = '0;
   logic [COORD_BITS-1:0] last_kept_y = '0;
   logic [COORD_BITS-1:0] first_x     = '0;
   logic [COORD_BITS-1:0] first_y     = '0;
   logic [INDEX_BITS-1:0] point_index = '0;
   logic                  waiting_start = 1'b1;

   function automatic int coord_distance(logic [COORD_BITS-1:0] a, logic [COORD_BITS-1:0] b);
      return (a > b) ? int'(a - b) : int'(b - a);
   endfunction

   function automatic void push_kept(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                                     logic closed);
      kept_point_type k;
      k.x = x;
      k.y = y;
      k.closed = closed;
      expected_points.insert(expected_points.size(), k);
   endfunction

   function automatic void decimate_point(contour_point_type p);
      if (p.start) begin
         first_x = p.x;
         first_y = p.y;
         last_kept_x = p.x;
         last_kept_y = p.y;
         point_index = '0;
         waiting_start = 1'b0;
         push_kept(p.x, p.y, 1'b0);
      end else if (!waiting_start) begin
         if (point_index != INDEX_MAX) point_index = point_index + 1'b1;
         if (coord_distance(p.x, last_kept_x) > step_limit ||
             coord_distance(p.y, last_kept_y) > step_limit) begin
            push_kept(p.x, p.y, 1'b0);
            last_kept_x = p.x;
            last_kept_y = p.y;
         end
         if (int'(point_index) > close_after &&
             coord_distance(p.x, first_x) < close_limit &&
             coord_distance(p.y, first_y) < close_limit) begin
            push_kept(first_x, first_y, 1'b1);
            waiting_start = 1'b1;
         end
      end
   endfunction

   // driver: an item stays on the port until taken
   always @(posedge clock) begin
      contour_point_type cur, nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            cur.x = req_point_x;
            cur.y = req_point_y;
            cur.start = req_run_start;
            decimate_point(cur);
         end
         if (!req_valid || !req_stall) begin
            if (pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_points.pop_front();
               req_valid <= 1'b1;
               req_point_x <= nxt.x;
               req_point_y <= nxt.y;
               req_run_start <= nxt.start;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall, with a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      kept_point_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected item x=%0d y=%0d closed=%0b", $time,
                     rsp_out_x, rsp_out_y, rsp_run_closed);
            error_count++;
         end else begin
            want = expected_points.pop_front();
            if (rsp_out_x !== want.x) begin
               $display("%0t: out_x expected %0d actual %0d", $time, want.x, rsp_out_x);
               error_count++;
            end
            if (rsp_out_y !== want.y) begin
               $display("%0t: out_y expected %0d actual %0d", $time, want.y, rsp_out_y);
               error_count++;
            end
            if (rsp_run_closed !== want.closed) begin
               $display("%0t: run_closed expected %0b actual %0b", $time, want.closed,
                        rsp_run_closed);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic add_point(int x, int y, bit start);
      contour_point_type p;
      p.x = x[COORD_BITS-1:0];
      p.y = y[COORD_BITS-1:0];
      p.start = start;
      pending_points.insert(pending_points.size(), p);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (pending_points.size() != 0 || req_valid || expected_points.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_BITS-1:0] idx, int value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value[CSR_DAT_BITS-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic configure_decimator(int step, int radius, int after);
      write_register(REG_STEP_THRESHOLD, step);
      step_limit = step;
      write_register(REG_CLOSE_RADIUS, radius);
      close_limit = radius;
      write_register(REG_CLOSE_AFTER_INDEX, after);
      close_after = after;
      @(negedge clock);
   endtask

   // closed loop: wander out, retrace back toward the start, with some noise
   task automatic add_contour(int n_points, int stride);
      int x, y, half, d;
      int dx[$];
      int dy[$];
      x = $urandom_range(4095);
      y = $urandom_range(4095);
      half = n_points / 2;
      add_point(x, y, 1'b1);
      for (int i = 0; i < half; i++) begin
         dx.insert(dx.size(), $urandom_range(2 * stride) - stride);
         dy.insert(dy.size(), $urandom_range(2 * stride) - stride);
         x = x + dx[i];
         y = y + dy[i];
         add_point(x, y, 1'b0);
      end
      // broken sequence: abandon the loop without returning
      if ($urandom_range(9) == 0) return;
      for (int i = half - 1; i >= 0; i--) begin
         d = $urandom_range(4) - 2;
         x = x - dx[i] + d;
         y = y - dy[i] - d;
         if ($urandom_range(99) < 6)
            add_point($urandom_range(4095), $urandom_range(4095), $urandom_range(7) == 0);
         else
            add_point(x, y, 1'b0);
      end
      add_point(x + 1, y, 1'b0);
   endtask

   task automatic random_phase(int target);
      int queued_before;
      queued_before = pending_points.size();
      while (pending_points.size() - queued_before < target) begin
         if ($urandom_range(9) == 0)
            add_point($urandom_range(4095), $urandom_range(4095), $urandom_range(1));
         else
            add_contour($urandom_range(6, 30), $urandom_range(1, 60));
      end
   endtask

   initial begin
      int x, y;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: ignored input, extremes, start during a run, threshold edge
      add_point(123, 456, 1'b0);
      add_point(0, 0, 1'b1);
      add_point(4095, 4095, 1'b0);
      add_point(4095, 0, 1'b1);
      add_point(4085, 0, 1'b0);
      add_point(4084, 11, 1'b0);
      add_point(2730, 1365, 1'b0);
      wait_idle();

      // immediate closure, closure alone and closure with step together
      configure_decimator(0, 255, 0);
      add_point(2000, 2000, 1'b1);
      add_point(2000, 2000, 1'b0);
      add_point(100, 100, 1'b0);
      add_point(3000, 3000, 1'b1);
      add_point(3001, 3254, 1'b0);
      add_point(3001, 3255, 1'b0);
      add_point(1365, 2730, 1'b1);
      add_point(1365, 2985, 1'b0);
      wait_idle();

      // widest step, zero radius: never closes
      configure_decimator(255, 0, 1023);
      add_point(0, 4095, 1'b1);
      add_point(255, 4095, 1'b0);
      add_point(256, 4095, 1'b0);
      add_point(256, 3840, 1'b0);
      add_point(256, 3839, 1'b0);
      add_point(0, 4095, 1'b0);
      wait_idle();

      for (int ph = 0; ph < 5; ph++) begin
         if (ph == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else begin
            send_idle_pct = IDLE_PCT;
            recv_idle_pct = IDLE_PCT;
         end
         case ($urandom_range(5))
            0: configure_decimator(255, 255, 0);
            1: configure_decimator(0, $urandom_range(1, 255), $urandom_range(0, 15));
            default: configure_decimator($urandom_range(0, 40), $urandom_range(1, 40),
                                         $urandom_range(0, 15));
         endcase
         random_phase(45);
         wait_idle();
      end

      // receiver holds off while the sender keeps offering moving points
      send_idle_pct = 0;
      recv_idle_pct = IDLE_PCT;
      configure_decimator(0, 8, 1023);
      add_point(500, 500, 1'b1);
      for (int i = 1; i <= 60; i++) add_point(500 + 20 * i, 500 + 3 * i, 1'b0);
      hold_requests++;
      wait_idle();
      send_idle_pct = IDLE_PCT;

      // longer run: closure only once the index passes the limit
      configure_decimator($urandom_range(0, 30), 40, 20);
      add_point(1000, 1000, 1'b1);
      for (int i = 0; i < 30; i++) begin
         x = $urandom_range(2000, 3000);
         y = $urandom_range(2000, 3000);
         add_point(x, y, 1'b0);
      end
      add_point(1005, 995, 1'b0);
      add_point(1000, 1000, 1'b0);
      wait_idle();

      configure_decimator(STEP_THRESHOLD_RESET, CLOSE_RADIUS_RESET, CLOSE_AFTER_INDEX_RESET);
      random_phase(30);
      wait_idle();

      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: contour_point_decimator.f
sv/cpd_pkg.sv
sv/cpd_front.sv
sv/cpd_queue.sv
sv/cpd_back.sv
sv/contour_point_decimator.sv
tb/contour_point_decimator_test.sv
